/* rtl/core/vsp_pkg.sv */
package vsp_pkg;

  localparam int unsigned CH_W        = 8;
  localparam int unsigned NUM_W       = 32;
  localparam int unsigned KW_N        = 5;
  localparam int unsigned OFF_W       = 3;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [KW_N-1:0] ALL_LIVE = '1;

  typedef enum logic [3:0] {
    PH_START  = 4'd0,
    PH_CVS    = 4'd1,
    PH_GROUP  = 4'd2,
    PH_LETTER = 4'd3,
    PH_KEY    = 4'd4,
    PH_SUFNUM = 4'd5,
    PH_REV_R  = 4'd6,
    PH_REV    = 4'd7
  } phase_e;

  typedef enum logic [2:0] {
    SK_ALPHA = 3'd0,
    SK_BETA  = 3'd1,
    SK_PRE   = 3'd2,
    SK_RC    = 3'd3,
    SK_TERM  = 3'd4,
    SK_P     = 3'd5
  } suffix_kind_e;

  typedef enum logic {
    EK_SUFFIX  = 1'b0,
    EK_SUMMARY = 1'b1
  } entry_kind_e;

  // Results caused by one character: an optional suffix word and an optional summary.
  typedef struct packed {
    logic             sfx_v;
    suffix_kind_e     sfx_kind;
    logic [NUM_W-1:0] sfx_num;
    logic             sum_v;
    logic             sum_err;
    logic             is_cvs;
    logic             has_rev;
    logic [NUM_W-1:0] rev;
  } vsp_event_t;

  typedef struct packed {
    entry_kind_e      entry_kind;
    suffix_kind_e     suffix_kind;
    logic [NUM_W-1:0] suffix_number;
    logic             status;
    logic             is_cvs;
    logic             has_revision;
    logic [NUM_W-1:0] revision;
    logic             run_end;
  } vsp_result_t;

  function automatic logic is_digit(input logic [CH_W-1:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [CH_W-1:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  // acc * 10 + digit, held at all ones once it overflows.
  function automatic logic [NUM_W-1:0] acc_digit(input logic [NUM_W-1:0] acc,
                                                  input logic [CH_W-1:0]  c);
    logic [NUM_W+3:0] w;
    w = (NUM_W + 4)'({acc, 3'b000}) + (NUM_W + 4)'({acc, 1'b0})
        + (NUM_W + 4)'(c - CH_W'(48));
    return (|w[NUM_W+3:NUM_W]) ? '1 : w[NUM_W-1:0];
  endfunction

  function automatic logic [CH_W-1:0] cvs_char(input logic [OFF_W-1:0] off);
    logic [CH_W-1:0] r;
    case (off)
      3'd0:    r = "c";
      3'd1:    r = "v";
      3'd2:    r = "s";
      3'd3:    r = ".";
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [OFF_W-1:0] kw_len(input logic [2:0] k);
    return 3'd5 - k;
  endfunction

  function automatic logic [CH_W-1:0] kw_char(input logic [2:0] k, input logic [OFF_W-1:0] off);
    logic [5*CH_W-1:0] txt;
    logic [CH_W-1:0]   r;
    unique case (k)
      3'd0:    txt = "alpha";
      3'd1:    txt = {"beta", 8'h00};
      3'd2:    txt = {"pre", 16'h0000};
      3'd3:    txt = {"rc", 24'h000000};
      default: txt = {"p", 32'h00000000};
    endcase
    case (off)
      3'd0:    r = txt[39:32];
      3'd1:    r = txt[31:24];
      3'd2:    r = txt[23:16];
      3'd3:    r = txt[15:8];
      3'd4:    r = txt[7:0];
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic suffix_kind_e kw_code(input logic [2:0] k);
    suffix_kind_e r;
    unique case (k)
      3'd0:    r = SK_ALPHA;
      3'd1:    r = SK_BETA;
      3'd2:    r = SK_PRE;
      3'd3:    r = SK_RC;
      default: r = SK_P;
    endcase
    return r;
  endfunction

  // Lowest live keyword whose length equals the offset; bit 3 flags a hit.
  function automatic logic [3:0] kw_done(input logic [KW_N-1:0] cand,
                                         input logic [OFF_W-1:0] off);
    logic [3:0] r;
    r = '0;
    for (int k = KW_N - 1; k >= 0; k--) begin
      if (cand[k] && (kw_len(3'(k)) == off)) begin
        r = {1'b1, 3'(k)};
      end
    end
    return r;
  endfunction

  function automatic logic [2:0] kw_first(input logic [KW_N-1:0] cand);
    logic [2:0] r;
    r = 3'd4;
    for (int k = KW_N - 1; k >= 0; k--) begin
      if (cand[k]) begin
        r = 3'(k);
      end
    end
    return r;
  endfunction

endpackage

/* rtl/core/vsp_char_if.sv */
interface vsp_char_if import vsp_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] ch;
  logic            last;

  modport source (output valid, ch, last, input ready);
  modport sink (input valid, ch, last, output ready);
endinterface

/* rtl/core/vsp_result_if.sv */
interface vsp_result_if import vsp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             entry_kind;
  logic [2:0]       suffix_kind;
  logic [NUM_W-1:0] suffix_number;
  logic             status;
  logic             is_cvs;
  logic             has_revision;
  logic [NUM_W-1:0] revision;
  logic             run_end;

  modport source (output valid, entry_kind, suffix_kind, suffix_number, status, is_cvs,
                  has_revision, revision, run_end, input ready);
  modport sink (input valid, entry_kind, suffix_kind, suffix_number, status, is_cvs,
                has_revision, revision, run_end, output ready);
endinterface

/* rtl/core/version_string_parser_core.sv */
// Version string checker, one character per word.
//
// char_i carries one ASCII byte per word (ch) and a flag on the final byte of a
// string (last). result_o carries result words: a suffix word (entry_kind 0)
// each time a _alpha/_beta/_pre/_rc/_p suffix completes, and a summary word
// (entry_kind 1) on the final byte with status, is_cvs and the -r revision.
// run_end marks the last word caused by one character.
//
// The parser takes one character per cycle while the event queue is not full;
// each accepted character updates the parse state. Its results go through a
// four-entry event queue to an output register, so the first word for a
// character passes through the queue and then through the output register. A final
// character that also closes a suffix yields two words, suffix then summary,
// from the same queue entry. Sustained rate is one character per cycle while
// result_o is not stalled. When result_o stalls, the output register holds its
// word, the queue fills, and char_i.ready drops once it is full.
// Reset returns the parser to the start of a string and empties the queue
// and the output register.
module version_string_parser_core import vsp_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  vsp_char_if.sink     char_i,
  vsp_result_if.source result_o
);

  logic       push;
  logic       pop;
  logic       empty;
  logic       full;
  vsp_event_t ev;
  vsp_event_t head;

  vsp_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .char_i  (char_i),
    .full_i  (full),
    .push_o  (push),
    .event_o (ev)
  );

  vsp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (ev),
    .pop_i   (pop),
    .data_o  (head),
    .empty_o (empty),
    .full_o  (full)
  );

  vsp_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .empty_i  (empty),
    .pop_o    (pop),
    .result_o (result_o)
  );

endmodule

/* rtl/core/vsp_front.sv */
module vsp_front import vsp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  vsp_char_if.sink   char_i,
  input  logic       full_i,
  output logic       push_o,
  output vsp_event_t event_o
);

  phase_e           ph_q, ph_d;
  logic             cvs_q, cvs_d;
  logic             err_q, err_d;
  logic [KW_N-1:0]  cand_q, cand_d;
  logic [OFF_W-1:0] off_q, off_d;
  logic [NUM_W-1:0] num_q, num_d;
  logic [NUM_W-1:0] rev_q, rev_d;
  logic             gds_q, gds_d;

  logic [CH_W-1:0]  c;
  logic             take;
  vsp_event_t       ev;

  assign c            = char_i.ch;
  assign char_i.ready = !full_i;
  assign take         = char_i.valid && char_i.ready;
  assign push_o       = take && (ev.sfx_v || ev.sum_v);
  assign event_o      = ev;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_START;
    end else if (take) begin
      ph_q <= ph_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cvs_q  <= 1'b0;
      err_q  <= 1'b0;
      cand_q <= ALL_LIVE;
      off_q  <= '0;
      num_q  <= '0;
      rev_q  <= '0;
      gds_q  <= 1'b0;
    end else if (take) begin
      cvs_q  <= cvs_d;
      err_q  <= err_d;
      cand_q <= cand_d;
      off_q  <= off_d;
      num_q  <= num_d;
      rev_q  <= rev_d;
      gds_q  <= gds_d;
    end
  end

  always_comb begin
    logic [KW_N-1:0] live;
    logic [3:0]      done;
    logic            do_end;
    suffix_kind_e    end_kind;
    logic            err_f;
    logic            hr;

    ph_d     = ph_q;
    cvs_d    = cvs_q;
    err_d    = err_q;
    cand_d   = cand_q;
    off_d    = off_q;
    num_d    = num_q;
    rev_d    = rev_q;
    gds_d    = gds_q;
    live     = '0;
    done     = '0;
    do_end   = 1'b0;
    end_kind = SK_TERM;
    err_f    = 1'b0;
    hr       = 1'b0;
    ev       = '0;
    ev.sfx_kind = SK_TERM;

    if (!err_q) begin
      unique case (ph_q)
        PH_START: begin
          if (c == "c") begin
            ph_d  = PH_CVS;
            off_d = 3'd1;
          end else if (is_digit(c)) begin
            ph_d  = PH_GROUP;
            gds_d = 1'b1;
          end else begin
            err_d = 1'b1;
          end
        end
        PH_CVS: begin
          if ((off_q < 3'd4) && (c == cvs_char(off_q))) begin
            off_d = off_q + 3'd1;
            if (off_q == 3'd3) begin
              cvs_d = 1'b1;
              ph_d  = PH_GROUP;
              gds_d = 1'b0;
              off_d = '0;
            end
          end else begin
            err_d = 1'b1;
          end
        end
        PH_GROUP: begin
          if (is_digit(c)) begin
            gds_d = 1'b1;
          end else if (!gds_q) begin
            err_d = 1'b1;
          end else if (c == ".") begin
            gds_d = 1'b0;
          end else if (is_alpha(c)) begin
            ph_d = PH_LETTER;
          end else if (c == "_") begin
            ph_d   = PH_KEY;
            cand_d = ALL_LIVE;
            off_d  = '0;
            num_d  = '0;
          end else if (c == "-") begin
            ph_d = PH_REV_R;
          end else begin
            err_d = 1'b1;
          end
        end
        PH_LETTER: begin
          if (c == "_") begin
            ph_d   = PH_KEY;
            cand_d = ALL_LIVE;
            off_d  = '0;
            num_d  = '0;
          end else if (c == "-") begin
            ph_d = PH_REV_R;
          end else begin
            err_d = 1'b1;
          end
        end
        PH_KEY: begin
          for (int k = 0; k < KW_N; k++) begin
            if (cand_q[k] && (off_q < kw_len(3'(k))) && (c == kw_char(3'(k), off_q))) begin
              live[k] = 1'b1;
            end
          end
          done = kw_done(cand_q, off_q);
          if (live != '0) begin
            cand_d = live;
            off_d  = off_q + 3'd1;
          end else if (!done[3]) begin
            err_d = 1'b1;
          end else begin
            cand_d = KW_N'(1) << done[2:0];
            if (is_digit(c)) begin
              num_d = acc_digit('0, c);
              ph_d  = PH_SUFNUM;
            end else begin
              do_end   = 1'b1;
              end_kind = kw_code(done[2:0]);
            end
          end
        end
        PH_SUFNUM: begin
          if (is_digit(c)) begin
            num_d = acc_digit(num_q, c);
          end else begin
            do_end   = 1'b1;
            end_kind = kw_code(kw_first(cand_q));
          end
        end
        PH_REV_R: begin
          if (c == "r") begin
            ph_d  = PH_REV;
            gds_d = 1'b0;
          end else begin
            err_d = 1'b1;
          end
        end
        PH_REV: begin
          if (is_digit(c)) begin
            gds_d = 1'b1;
            rev_d = acc_digit(rev_q, c);
          end else begin
            err_d = 1'b1;
          end
        end
        default: begin
          err_d = 1'b1;
        end
      endcase
    end

    // A completed suffix is closed by the next underscore or by a dash.
    if (do_end) begin
      if ((c == "_") || (c == "-")) begin
        ev.sfx_v    = 1'b1;
        ev.sfx_kind = end_kind;
        ev.sfx_num  = num_q;
        if (c == "_") begin
          ph_d   = PH_KEY;
          cand_d = ALL_LIVE;
          off_d  = '0;
          num_d  = '0;
        end else begin
          ph_d = PH_REV_R;
        end
      end else begin
        err_d = 1'b1;
      end
    end

    ev.is_cvs = cvs_d;

    if (char_i.last) begin
      err_f = err_d;
      if (!err_d) begin
        case (ph_d)
          PH_GROUP: begin
            if (!gds_d) begin
              err_f = 1'b1;
            end
          end
          PH_LETTER: begin
            err_f = 1'b0;
          end
          PH_KEY: begin
            done = kw_done(cand_d, off_d);
            if (!done[3]) begin
              err_f = 1'b1;
            end else begin
              ev.sfx_v    = 1'b1;
              ev.sfx_kind = kw_code(done[2:0]);
              ev.sfx_num  = '0;
            end
          end
          PH_SUFNUM: begin
            ev.sfx_v    = 1'b1;
            ev.sfx_kind = kw_code(kw_first(cand_d));
            ev.sfx_num  = num_d;
          end
          PH_REV: begin
            if (!gds_d) begin
              err_f = 1'b1;
            end else begin
              hr = 1'b1;
            end
          end
          default: begin
            err_f = 1'b1;
          end
        endcase
      end
      ev.sum_v   = 1'b1;
      ev.sum_err = err_f;
      ev.has_rev = hr && !err_f;
      ev.rev     = (hr && !err_f) ? rev_d : '0;

      // The next character starts a new string.
      ph_d   = PH_START;
      cvs_d  = 1'b0;
      err_d  = 1'b0;
      cand_d = ALL_LIVE;
      off_d  = '0;
      num_d  = '0;
      rev_d  = '0;
      gds_d  = 1'b0;
    end
  end

  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && char_i.last) |=> ((ph_q == PH_START) && !err_q && !cvs_q))
    else $error("parser did not return to the start of a string after the final character");

endmodule

/* rtl/core/vsp_queue.sv */
module vsp_queue import vsp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  vsp_event_t data_i,
  input  logic       pop_i,
  output vsp_event_t data_o,
  output logic       empty_o,
  output logic       full_o
);

  vsp_event_t        mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign data_o  = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_q <= wr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("event queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("event queue read while empty");

endmodule

/* rtl/core/vsp_back.sv */
module vsp_back import vsp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  vsp_event_t  head_i,
  input  logic        empty_i,
  output logic        pop_o,
  vsp_result_if.source result_o
);

  logic        out_v_q, out_v_d;
  vsp_result_t out_q, out_d;
  logic        sfx_done_q, sfx_done_d;
  logic        load;

  assign load = !out_v_q || result_o.ready;

  always_comb begin
    out_v_d    = out_v_q;
    out_d      = out_q;
    sfx_done_d = sfx_done_q;
    pop_o      = 1'b0;
    if (load) begin
      out_v_d = !empty_i;
      if (!empty_i) begin
        out_d.is_cvs = head_i.is_cvs;
        if (head_i.sfx_v && !sfx_done_q) begin
          out_d.entry_kind    = EK_SUFFIX;
          out_d.suffix_kind   = head_i.sfx_kind;
          out_d.suffix_number = head_i.sfx_num;
          out_d.status        = 1'b0;
          out_d.has_revision  = 1'b0;
          out_d.revision      = '0;
          out_d.run_end       = !head_i.sum_v;
          // A summary follows in the same event: hold the head one more word.
          if (head_i.sum_v) begin
            sfx_done_d = 1'b1;
          end else begin
            pop_o = 1'b1;
          end
        end else begin
          out_d.entry_kind    = EK_SUMMARY;
          out_d.suffix_kind   = SK_TERM;
          out_d.suffix_number = '0;
          out_d.status        = head_i.sum_err;
          out_d.has_revision  = head_i.has_rev;
          out_d.revision      = head_i.rev;
          out_d.run_end       = 1'b1;
          pop_o               = 1'b1;
          sfx_done_d          = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q    <= 1'b0;
      sfx_done_q <= 1'b0;
    end else begin
      out_v_q    <= out_v_d;
      sfx_done_q <= sfx_done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign result_o.valid         = out_v_q;
  assign result_o.entry_kind    = out_q.entry_kind;
  assign result_o.suffix_kind   = out_q.suffix_kind;
  assign result_o.suffix_number = out_q.suffix_number;
  assign result_o.status        = out_q.status;
  assign result_o.is_cvs        = out_q.is_cvs;
  assign result_o.has_revision  = out_q.has_revision;
  assign result_o.revision      = out_q.revision;
  assign result_o.run_end       = out_q.run_end;

  a_summary_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && (result_o.entry_kind == EK_SUMMARY)) |-> result_o.run_end)
    else $error("summary word without run_end");

endmodule

/* sim/tb.sv */
module tb;
  import vsp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 10;
  localparam int RANDOM_CHARS = 325;
  localparam int NROWS = 26;

  localparam logic [31:0] CVS_TAG = "cvs.";
  localparam logic [39:0] KW_TEXT [5] = '{"alpha", "beta", "pre", "rc", "p"};
  localparam int KW_LEN [5] = '{5, 4, 3, 2, 1};
  localparam suffix_kind_e KW_KIND [5] = '{SK_ALPHA, SK_BETA, SK_PRE, SK_RC, SK_P};
  localparam logic [63:0] JUNK = "._-rcp0a";

  // One directed string; the summary fields count only where typed is set.
  typedef struct packed {
    logic [8*40-1:0] text;
    logic            typed;
    logic            bad;
    logic            cvs;
    logic            has_rev;
    logic [31:0]     rev;
  } row_t;

  localparam row_t NOT_TYPED = '0;

  localparam row_t ROWS [NROWS] = '{
    '{"0",                1'b1, 1'b0, 1'b0, 1'b0, 32'd0},
    '{"4294967295.0.9",   1'b1, 1'b0, 1'b0, 1'b0, 32'd0},
    '{"1-r4294967295",    1'b1, 1'b0, 1'b0, 1'b1, 32'hFFFF_FFFF},
    '{"1-r99999999999",   1'b1, 1'b0, 1'b0, 1'b1, 32'hFFFF_FFFF},
    '{"cvs.1-r0",         1'b1, 1'b0, 1'b1, 1'b1, 32'd0},
    '{"cvs.20z-r3",       1'b1, 1'b0, 1'b1, 1'b1, 32'd3},
    '{"9Z",               1'b1, 1'b0, 1'b0, 1'b0, 32'd0},
    '{"x",                1'b1, 1'b1, 1'b0, 1'b0, 32'd0},
    '{"\377",             1'b1, 1'b1, 1'b0, 1'b0, 32'd0},
    '{"cv",               1'b1, 1'b1, 1'b0, 1'b0, 32'd0},
    '{"cvs.",             1'b1, 1'b1, 1'b1, 1'b0, 32'd0},
    '{"1.",               1'b1, 1'b1, 1'b0, 1'b0, 32'd0},
    '{"1..2",             1'b1, 1'b1, 1'b0, 1'b0, 32'd0},
    '{"1-",               1'b1, 1'b1, 1'b0, 1'b0, 32'd0},
    '{"1-r",              1'b1, 1'b1, 1'b0, 1'b0, 32'd0},
    '{"1-r5x",            1'b1, 1'b1, 1'b0, 1'b0, 32'd0},
    '{"1ab",              1'b1, 1'b1, 1'b0, 1'b0, 32'd0},
    '{"1_",               1'b1, 1'b1, 1'b0, 1'b0, 32'd0},
    '{"1_alp",            1'b1, 1'b1, 1'b0, 1'b0, 32'd0},
    '{"1_pr5",            1'b1, 1'b1, 1'b0, 1'b0, 32'd0},
    '{"1_beta1x",         1'b1, 1'b1, 1'b0, 1'b0, 32'd0},
    '{"1.2b_alpha_beta2_pre_rc4294967296_p-r7", 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
    '{"cvs.1_p",          1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
    '{"1_pre99",          1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
    '{"1_alpha_",         1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
    '{"3_rc5-",           1'b0, 1'b0, 1'b0, 1'b0, 32'd0}
  };

  logic clk_i;
  logic rst_ni;

  vsp_char_if   ch_if ();
  vsp_result_if res_if ();

  version_string_parser_core dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .char_i   (ch_if),
    .result_o (res_if)
  );

  // Parser state as the checker sees it.
  phase_e      parse_phase;
  logic        cvs_on;
  logic        failed;
  logic        digit_seen;
  logic [4:0]  live_kw;
  logic [2:0]  kw_pos;
  logic [31:0] sfx_acc;
  logic [31:0] rev_acc;

  vsp_result_t expected_words [$];
  vsp_result_t char_words [$];
  logic [7:0]  spelled [$];
  int          parsed_chars;
  int          mismatches;
  logic        no_idle;
  logic        stall_request;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic digit_char(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [7:0] keyword_byte(int k, int o);
    return KW_TEXT[k][8*(KW_LEN[k]-1-o) +: 8];
  endfunction

  function automatic logic [31:0] append_digit(logic [31:0] acc, logic [7:0] c);
    logic [35:0] wide;
    wide = 36'(acc) * 36'd10 + 36'(c - "0");
    return (wide > 36'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
  endfunction

  // Lowest live keyword whose full length has been matched, or -1.
  function automatic int finished_keyword();
    for (int k = 0; k < 5; k++) begin
      if (live_kw[k] && KW_LEN[k] == int'(kw_pos)) return k;
    end
    return -1;
  endfunction

  function automatic int sole_keyword();
    for (int k = 0; k < 5; k++) begin
      if (live_kw[k]) return k;
    end
    return 4;
  endfunction

  function automatic vsp_result_t make_word(entry_kind_e ek, suffix_kind_e sk,
                                            logic [31:0] num, logic bad, logic hr,
                                            logic [31:0] rev);
    vsp_result_t w;
    w.entry_kind    = ek;
    w.suffix_kind   = sk;
    w.suffix_number = num;
    w.status        = bad;
    w.is_cvs        = cvs_on;
    w.has_revision  = hr;
    w.revision      = rev;
    w.run_end       = 1'b0;
    return w;
  endfunction

  task automatic reset_parser();
    parse_phase = PH_START;
    cvs_on      = 1'b0;
    failed      = 1'b0;
    digit_seen  = 1'b0;
    live_kw     = 5'b11111;
    kw_pos      = '0;
    sfx_acc     = '0;
    rev_acc     = '0;
  endtask

  task automatic enter_keyword();
    parse_phase = PH_KEY;
    live_kw     = 5'b11111;
    kw_pos      = '0;
    sfx_acc     = '0;
  endtask

  // A finished suffix is closed by an underscore or a dash; anything else is an error.
  task automatic close_suffix(logic [7:0] c, int k);
    if (c == "_" || c == "-") begin
      char_words.push_back(make_word(EK_SUFFIX, KW_KIND[k], sfx_acc, 1'b0, 1'b0, 32'd0));
      if (c == "_") begin
        enter_keyword();
      end else begin
        parse_phase = PH_REV_R;
      end
    end else begin
      failed = 1'b1;
    end
  endtask

  task automatic parse_char(logic [7:0] c, logic fin);
    logic [4:0]  hits;
    logic        hr;
    int          k;
    vsp_result_t w;
    char_words.delete();
    if (!failed) begin
      parsed_chars++;
      case (parse_phase)
        PH_START: begin
          if (c == "c") begin
            parse_phase = PH_CVS;
            kw_pos = 3'd1;
          end else if (digit_char(c)) begin
            parse_phase = PH_GROUP;
            digit_seen = 1'b1;
          end else begin
            failed = 1'b1;
          end
        end
        PH_CVS: begin
          if (kw_pos < 3'd4 && c == CVS_TAG[8*(3-int'(kw_pos)) +: 8]) begin
            kw_pos++;
            if (kw_pos == 3'd4) begin
              cvs_on = 1'b1;
              parse_phase = PH_GROUP;
              digit_seen = 1'b0;
              kw_pos = '0;
            end
          end else begin
            failed = 1'b1;
          end
        end
        PH_GROUP: begin
          if (digit_char(c)) begin
            digit_seen = 1'b1;
          end else if (!digit_seen) begin
            failed = 1'b1;
          end else if (c == ".") begin
            digit_seen = 1'b0;
          end else if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) begin
            parse_phase = PH_LETTER;
          end else if (c == "_") begin
            enter_keyword();
          end else if (c == "-") begin
            parse_phase = PH_REV_R;
          end else begin
            failed = 1'b1;
          end
        end
        PH_LETTER: begin
          if (c == "_") begin
            enter_keyword();
          end else if (c == "-") begin
            parse_phase = PH_REV_R;
          end else begin
            failed = 1'b1;
          end
        end
        PH_KEY: begin
          hits = '0;
          for (int i = 0; i < 5; i++) begin
            if (live_kw[i] && int'(kw_pos) < KW_LEN[i] && c == keyword_byte(i, int'(kw_pos)))
              hits[i] = 1'b1;
          end
          if (hits != '0) begin
            live_kw = hits;
            kw_pos++;
          end else begin
            // No keyword can grow, so the longest one already complete wins.
            k = finished_keyword();
            if (k < 0) begin
              failed = 1'b1;
            end else begin
              live_kw = 5'b00001 << k;
              if (digit_char(c)) begin
                sfx_acc = append_digit(32'd0, c);
                parse_phase = PH_SUFNUM;
              end else begin
                close_suffix(c, k);
              end
            end
          end
        end
        PH_SUFNUM: begin
          if (digit_char(c)) begin
            sfx_acc = append_digit(sfx_acc, c);
          end else begin
            close_suffix(c, sole_keyword());
          end
        end
        PH_REV_R: begin
          if (c == "r") begin
            parse_phase = PH_REV;
            digit_seen = 1'b0;
          end else begin
            failed = 1'b1;
          end
        end
        PH_REV: begin
          if (digit_char(c)) begin
            digit_seen = 1'b1;
            rev_acc = append_digit(rev_acc, c);
          end else begin
            failed = 1'b1;
          end
        end
        default: failed = 1'b1;
      endcase
    end
    if (fin) begin
      hr = 1'b0;
      if (!failed) begin
        case (parse_phase)
          PH_GROUP: if (!digit_seen) failed = 1'b1;
          PH_LETTER: ;
          PH_KEY: begin
            k = finished_keyword();
            if (k < 0) begin
              failed = 1'b1;
            end else begin
              char_words.push_back(make_word(EK_SUFFIX, KW_KIND[k], 32'd0, 1'b0, 1'b0, 32'd0));
            end
          end
          PH_SUFNUM: begin
            char_words.push_back(make_word(EK_SUFFIX, KW_KIND[sole_keyword()], sfx_acc,
                                           1'b0, 1'b0, 32'd0));
          end
          PH_REV: begin
            if (!digit_seen) begin
              failed = 1'b1;
            end else begin
              hr = 1'b1;
            end
          end
          default: failed = 1'b1;
        endcase
      end
      if (failed) begin
        char_words.push_back(make_word(EK_SUMMARY, SK_TERM, 32'd0, 1'b1, 1'b0, 32'd0));
      end else begin
        char_words.push_back(make_word(EK_SUMMARY, SK_TERM, 32'd0, 1'b0, hr,
                                       hr ? rev_acc : 32'd0));
      end
      reset_parser();
    end
    if (char_words.size() > 0) begin
      w = char_words.pop_back();
      w.run_end = 1'b1;
      char_words.push_back(w);
    end
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatches < 50) begin
      $display("%0t mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
    end
    mismatches++;
  endtask

  // Sends the characters in spelled, starting and ending at a falling edge.
  task automatic send_string(row_t row);
    logic fin;
    for (int i = 0; i < spelled.size(); i++) begin
      fin = (i == spelled.size() - 1);
      while (!no_idle && $urandom_range(99) < 9) begin
        ch_if.valid <= 1'b0;
        @(negedge clk_i);
      end
      ch_if.valid <= 1'b1;
      ch_if.ch    <= spelled[i];
      ch_if.last  <= fin;
      @(posedge clk_i);
      while (!ch_if.ready) @(posedge clk_i);
      parse_char(spelled[i], fin);
      if (row.typed && fin) begin
        expected_words.push_back(vsp_result_t'{EK_SUMMARY, SK_TERM, 32'd0, row.bad, row.cvs,
                                               row.has_rev, row.rev, 1'b1});
      end else begin
        foreach (char_words[j]) expected_words.push_back(char_words[j]);
      end
      @(negedge clk_i);
    end
  endtask

  task automatic add_digits();
    repeat (($urandom_range(7) == 0) ? 11 : $urandom_range(3, 1))
      spelled.push_back(8'("0" + $urandom_range(9)));
  endtask

  initial begin
    int pick;
    int pos;
    int k;
    int start_count;
    int strings_sent;
    rst_ni        = 1'b0;
    ch_if.valid   = 1'b0;
    ch_if.ch      = '0;
    ch_if.last    = 1'b0;
    no_idle       = 1'b0;
    stall_request = 1'b0;
    parsed_chars  = 0;
    mismatches    = 0;
    reset_parser();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int r = 0; r < NROWS; r++) begin
      spelled.delete();
      for (int b = 39; b >= 0; b--) begin
        if (spelled.size() > 0 || ROWS[r].text[8*b +: 8] != 8'd0)
          spelled.push_back(ROWS[r].text[8*b +: 8]);
      end
      send_string(ROWS[r]);
    end

    // Mostly well-formed strings with random content, some corrupted, some pure noise.
    start_count  = parsed_chars;
    strings_sent = 0;
    while (parsed_chars - start_count < RANDOM_CHARS) begin
      no_idle = (strings_sent >= 6 && strings_sent < 14);
      if (strings_sent == 8 || strings_sent == 16) stall_request = 1'b1;
      spelled.delete();
      pick = $urandom_range(99);
      if (pick < 10) begin
        repeat ($urandom_range(6, 1)) spelled.push_back(8'($urandom_range(255)));
      end else begin
        if ($urandom_range(3) == 0) begin
          for (int i = 0; i < 4; i++) spelled.push_back(CVS_TAG[8*(3-i) +: 8]);
        end
        add_digits();
        repeat ($urandom_range(2)) begin
          spelled.push_back(".");
          add_digits();
        end
        if ($urandom_range(3) == 0)
          spelled.push_back(8'(($urandom_range(1) ? "a" : "A") + $urandom_range(25)));
        repeat ($urandom_range(3)) begin
          spelled.push_back("_");
          k = $urandom_range(4);
          for (int i = 0; i < KW_LEN[k]; i++) spelled.push_back(keyword_byte(k, i));
          if ($urandom_range(1)) add_digits();
        end
        if ($urandom_range(2) == 0) begin
          spelled.push_back("-");
          spelled.push_back("r");
          add_digits();
        end
        if (pick < 30) begin
          pos = $urandom_range(spelled.size() - 1);
          case ($urandom_range(2))
            0:       spelled[pos] = 8'($urandom_range(255));
            1:       spelled = spelled[0:pos];
            default: spelled.insert(pos, JUNK[8*$urandom_range(7) +: 8]);
          endcase
        end
      end
      send_string(NOT_TYPED);
      strings_sent++;
    end
    no_idle = 1'b0;
    ch_if.valid <= 1'b0;

    wait (expected_words.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("[version_string_parser_core] OK");
    end else begin
      $display("[version_string_parser_core] ERROR");
    end
    $finish;
  end

  // Result side: random back-pressure plus long hold-offs on request.
  initial begin
    int hold;
    hold = 0;
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_request) begin
        hold = 80;
        stall_request = 1'b0;
      end
      if (hold > 0) begin
        res_if.ready <= 1'b0;
        hold--;
      end else begin
        res_if.ready <= no_idle || ($urandom_range(99) >= 9);
      end
    end
  end

  initial begin
    vsp_result_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_if.valid && res_if.ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch("word count", 32'd1, 32'd0);
        end else begin
          want = expected_words.pop_front();
          if (res_if.entry_kind !== want.entry_kind)
            report_mismatch("entry_kind", res_if.entry_kind, want.entry_kind);
          if (res_if.suffix_kind !== want.suffix_kind)
            report_mismatch("suffix_kind", res_if.suffix_kind, want.suffix_kind);
          if (res_if.suffix_number !== want.suffix_number)
            report_mismatch("suffix_number", res_if.suffix_number, want.suffix_number);
          if (res_if.status !== want.status)
            report_mismatch("status", res_if.status, want.status);
          if (res_if.is_cvs !== want.is_cvs)
            report_mismatch("is_cvs", res_if.is_cvs, want.is_cvs);
          if (res_if.has_revision !== want.has_revision)
            report_mismatch("has_revision", res_if.has_revision, want.has_revision);
          if (res_if.revision !== want.revision)
            report_mismatch("revision", res_if.revision, want.revision);
          if (res_if.run_end !== want.run_end)
            report_mismatch("run_end", res_if.run_end, want.run_end);
        end
      end
    end
  end

  // Ends the run if neither side moves a word for too long.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((ch_if.valid && ch_if.ready) || (res_if.valid && res_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("[version_string_parser_core] ERROR");
          $finish;
        end
      end
    end
  end

endmodule
